// ----- src/oets_pkg.sv -----
// Package for the odd-even transposition sorter.
// Holds sizes, word types, cell operation codes and controller states.
// No dependencies.
package oets_pkg;

    localparam int MAX_ITEMS  = 64;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);

    typedef logic signed [DATA_WIDTH-1:0] elem_t;
    typedef logic [CNT_W-1:0]             cnt_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               last_out;
        logic               overflowed;
    } out_word_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_SORT,
        OP_EMIT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     parity;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } state_t;

endpackage

// ----- src/odd_even_transposition_sort.sv -----
// Top level of the odd-even transposition sorter: chain of cells and sequencer.
// Depends on oets_pkg, oets_cell, oets_ctrl.
//
//   channel | direction | handshake          | word
//   s_      | in        | s_valid / s_ready  | in_word_t  (value, last)
//   m_      | out       | m_valid / m_ready  | out_word_t (sorted_value, last_out, overflowed)
//
// A set of n words is loaded word by word, sorted in n phases (each set by the
// compare-exchange step of the cell chain) and emitted word by word.
// Input is taken only while loading; results are shown only while emitting.
// Synchronous active-low reset clears the valid bits and the sequencer.
// A stalled m_ready holds the chain; the head cell is the output register.
module odd_even_transposition_sort
    import oets_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    cell_ctrl_t cell_ctrl;
    elem_t      cell_value [MAX_ITEMS];
    logic       cell_valid [MAX_ITEMS];
    logic       last_out;
    logic       overflowed;

    oets_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_last       (s_data.last),
        .s_ready      (s_ready),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_last_out   (last_out),
        .m_overflowed (overflowed),
        .cell_ctrl    (cell_ctrl)
    );

    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        elem_t left_value;
        logic  left_valid;
        elem_t right_value;
        logic  right_valid;

        if (i == 0) begin : g_head
            assign left_value = elem_t'(s_data.value);
            assign left_valid = (cell_ctrl.op == OP_LOAD);
        end else begin : g_mid
            assign left_value = cell_value[i-1];
            assign left_valid = cell_valid[i-1];
        end

        if (i == MAX_ITEMS - 1) begin : g_tail
            assign right_value = '0;
            assign right_valid = 1'b0;
        end else begin : g_body
            assign right_value = cell_value[i+1];
            assign right_valid = cell_valid[i+1];
        end

        oets_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (cell_ctrl),
            .is_odd      (1'(i % 2)),
            .left_value  (left_value),
            .left_valid  (left_valid),
            .right_value (right_value),
            .right_valid (right_valid),
            .value       (cell_value[i]),
            .valid       (cell_valid[i])
        );
    end

    assign m_data.sorted_value = 32'(cell_value[0]);
    assign m_data.last_out     = last_out;
    assign m_data.overflowed   = overflowed;

endmodule

// ----- src/oets_cell.sv -----
// One cell of the sorting chain: holds one element and its valid bit.
// Loads from the left, emits from the right, compare-exchanges with a neighbor.
// Depends on oets_pkg.
module oets_cell
    import oets_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  logic       is_odd,
    input  elem_t      left_value,
    input  logic       left_valid,
    input  elem_t      right_value,
    input  logic       right_valid,
    output elem_t      value,
    output logic       valid
);

    elem_t value_reg, value_next;
    logic  valid_reg, valid_next;
    logic  is_left;
    logic  swap_with_right;
    logic  swap_with_left;

    assign is_left         = (is_odd == ctrl.parity);
    assign swap_with_right = valid_reg && right_valid && (value_reg > right_value);
    assign swap_with_left  = valid_reg && left_valid && (left_value > value_reg);

    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        case (ctrl.op)
            OP_LOAD: begin
                value_next = left_value;
                valid_next = left_valid;
            end
            OP_SORT: begin
                if (is_left && swap_with_right) begin
                    value_next = right_value;
                end else if (!is_left && swap_with_left) begin
                    value_next = left_value;
                end
            end
            OP_EMIT: begin
                value_next = right_value;
                valid_next = right_valid;
            end
            default: begin
                value_next = value_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

// ----- src/oets_ctrl.sv -----
// Sequencer for the sorting chain: load, sort phases, emit.
// Tracks element count, phase number and the overflow mark.
// Depends on oets_pkg.
module oets_ctrl
    import oets_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_last,
    output logic       s_ready,
    input  logic       m_ready,
    output logic       m_valid,
    output logic       m_last_out,
    output logic       m_overflowed,
    output cell_ctrl_t cell_ctrl
);

    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    cnt_t   phase_reg, phase_next;
    logic   ovf_reg, ovf_next;
    logic   has_room;
    logic   sort_done;

    assign has_room  = (count_reg < CNT_W'(MAX_ITEMS));
    assign sort_done = (phase_reg == count_reg - cnt_t'(1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_valid && s_last) begin
                    state_next = ST_SORT;
                end
            end
            ST_SORT: begin
                if (sort_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (m_ready && (count_reg == cnt_t'(1))) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        s_ready          = 1'b0;
        m_valid          = 1'b0;
        cell_ctrl.op     = OP_HOLD;
        cell_ctrl.parity = phase_reg[0];
        case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid && has_room) begin
                    cell_ctrl.op = OP_LOAD;
                end
            end
            ST_SORT: begin
                cell_ctrl.op = OP_SORT;
            end
            ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cell_ctrl.op = OP_EMIT;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        count_next = count_reg;
        phase_next = phase_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    if (has_room) begin
                        count_next = count_reg + cnt_t'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    phase_next = '0;
                end
            end
            ST_SORT: begin
                phase_next = phase_reg + cnt_t'(1);
            end
            ST_EMIT: begin
                if (m_ready) begin
                    count_next = count_reg - cnt_t'(1);
                    if (count_reg == cnt_t'(1)) begin
                        ovf_next = 1'b0;
                    end
                end
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            phase_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign m_last_out   = (count_reg == cnt_t'(1));
    assign m_overflowed = ovf_reg;

endmodule

// ----- src/oets_checker.sv -----
// Port-level checks for the odd-even transposition sorter, bound to the top level.
// Depends on oets_pkg and odd_even_transposition_sort.
module oets_checker
    import oets_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_word_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while results pending");

    a_set_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.last_out |=> !m_valid && s_ready)
        else $error("results continue after final word");

    a_ovf_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_out
        |=> m_valid && (m_data.overflowed == $past(m_data.overflowed)))
        else $error("overflow mark changed within a set");

    a_last_sets: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.last |=> !s_ready)
        else $error("input still taken after final word of set");

endmodule

bind odd_even_transposition_sort oets_checker u_oets_checker (.*);

// ----- sim/sort_checker.sv -----
// Checker for the odd-even transposition sorter: watches both channels, predicts
// the sorted sets and compares every result word against the expected queue.
// Depends on oets_pkg.
module sort_checker
    import oets_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_word_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_word_t m_data,
    output int        mismatches,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    elem_t     held_values [MAX_ITEMS];
    int        held_count  = 0;
    logic      dropped     = 1'b0;
    out_word_t sorted_due [$];
    int        fault_count = 0;

    function automatic void sort_held();
        elem_t swap_tmp;
        for (int p = 0; p < held_count; p++) begin
            for (int j = p % 2; j + 1 < held_count; j += 2) begin
                if (held_values[j] > held_values[j + 1]) begin
                    swap_tmp            = held_values[j];
                    held_values[j]      = held_values[j + 1];
                    held_values[j + 1]  = swap_tmp;
                end
            end
        end
    endfunction

    function automatic void take_value(in_word_t w);
        out_word_t r;
        if (held_count < MAX_ITEMS) begin
            held_values[held_count] = elem_t'(w.value);
            held_count++;
        end else begin
            dropped = 1'b1;
        end
        if (w.last) begin
            sort_held();
            for (int k = 0; k < held_count; k++) begin
                r.sorted_value = 32'(held_values[k]);
                r.last_out     = (k == held_count - 1);
                r.overflowed   = dropped;
                sorted_due.push_back(r);
            end
            held_count = 0;
            dropped    = 1'b0;
        end
    endfunction

    task automatic note_fault(string what, out_word_t want, out_word_t got);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t: %s: expected value %0d last %0b ovf %0b, got value %0d last %0b ovf %0b",
                     $time, what, want.sorted_value, want.last_out, want.overflowed,
                     got.sorted_value, got.last_out, got.overflowed);
    endtask

    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            held_count = 0;
            dropped    = 1'b0;
            sorted_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (sorted_due.size() == 0) begin
                    note_fault("unexpected word", '0, m_data);
                end else begin
                    want = sorted_due.pop_front();
                    if (m_data.sorted_value !== want.sorted_value ||
                        m_data.last_out !== want.last_out ||
                        m_data.overflowed !== want.overflowed)
                        note_fault("wrong word", want, m_data);
                end
            end
            if (s_valid && s_ready)
                take_value(s_data);
        end
        mismatches <= fault_count;
        pending    <= sorted_due.size();
    end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the odd-even transposition sorter: clock, reset, set stimulus
// with random gaps and stalls, watchdog and verdict.
// Depends on oets_pkg, odd_even_transposition_sort and sort_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import oets_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 3 * MAX_ITEMS + 20;
    localparam int RANDOM_WORDS = 350;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    logic      calm        = 1'b0;
    int        stall_left  = 0;
    int        idle_cycles = 0;
    int        words_sent  = 0;
    int        mismatches;
    int        pending;
    logic signed [31:0] set_vals [$];

    initial forever #6 aclk = ~aclk;

    odd_even_transposition_sort dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    sort_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    function automatic int pick_gap(int zero_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 6);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 9))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return $signed($urandom_range(0, 15)) - 32'sd8;
            5: return $signed($urandom_range(0, 3));
            default: return $signed($urandom);
        endcase
    endfunction

    // hold m_ready low for random stretches unless the current set runs calm
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!calm && aresetn && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap(0) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(logic signed [31:0] v, logic lst);
        int gap;
        gap = calm ? 0 : pick_gap(55);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{value: v, last: lst};
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic send_set();
        foreach (set_vals[i])
            send_word(set_vals[i], i == set_vals.size() - 1);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        int n_set;
        int r;
        int set_idx;
        int target;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        set_vals = '{VAL_MAX};                              send_set();
        set_vals = '{VAL_MIN};                              send_set();
        set_vals = '{VAL_MAX, VAL_MIN};                     send_set();
        set_vals = '{VAL_MIN, VAL_MAX};                     send_set();
        set_vals = '{32'sd7, 32'sd7};                       send_set();
        set_vals = '{VAL_MAX, 32'sd1, 32'sd0, -32'sd1, VAL_MIN};
        send_set();
        set_vals = '{32'sd3, -32'sd3, 32'sd3, -32'sd3, 32'sd0};
        send_set();
        set_vals = '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F};
        send_set();

        target  = words_sent + RANDOM_WORDS;
        set_idx = 0;
        while (words_sent < target) begin
            case (set_idx)
                1: n_set = MAX_ITEMS + 2;
                6: n_set = MAX_ITEMS;
                default: begin
                    r = $urandom_range(0, 99);
                    if (r < 10)      n_set = 1;
                    else if (r < 82) n_set = $urandom_range(2, 12);
                    else if (r < 96) n_set = $urandom_range(13, 40);
                    else             n_set = $urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 6);
                end
            endcase
            calm <= ($urandom_range(0, 3) == 0);
            set_vals.delete();
            repeat (n_set) set_vals.push_back(rand_value());
            send_set();
            if (set_idx % 10 == 4)
                wait_drained();
            set_idx++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
